@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for concurrent assertions, clocked on a rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define ASQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// The condition must never be seen at a clock edge out of reset.
`define ASQ_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ rtl/asq_pkg.sv @@
// ----------------------------------------------------------------------------
// ADC scan stability qualifier package
// Widths, defaults, register map and the result word type.
// ----------------------------------------------------------------------------
package asq_pkg;

  localparam int AdcW  = 10;
  localparam int MvW   = 13;
  localparam int ChOutW = 4;

  localparam int DefSamplesPerChannel = 8;
  localparam int DefChannels          = 4;

  localparam logic [MvW-1:0] ThrResetMv = MvW'(50);

  // Register map: one 32-bit register per 4-byte slot.
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam int RegIdxW  = ApbAddrW - 2;
  localparam logic [RegIdxW-1:0] RegNoiseThr = RegIdxW'(0);

  typedef struct packed {
    logic              store_valid;
    logic [ChOutW-1:0] store_channel;
    logic [MvW-1:0]    settled_mv;
    logic              rejected;
    logic              scan_complete;
    logic              data_ready;
    logic [ChOutW-1:0] next_channel;
  } asq_result_t;

endpackage

@@ rtl/asq_if.sv @@
// ----------------------------------------------------------------------------
// ADC scan stability qualifier channels
// Valid/ready channels for the converter code words and the result words.
// ----------------------------------------------------------------------------
interface asq_in_if;
  import asq_pkg::*;

  logic            valid;
  logic            ready;
  logic [AdcW-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

interface asq_out_if;
  import asq_pkg::*;

  logic        valid;
  logic        ready;
  asq_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/adc_scan_stability_qualifier.sv @@
// A code word accepted by the input stage sits in the input register, then passes
// to the result register, where it is held until the result side takes it.
// Throughput: one word per cycle, sustained while the result side takes words.
// The input register can take a new word while a result waits, as long as it is empty.
// Reset (rst_ni low, asynchronous): counters, previous value and the ready
// flag clear, the threshold returns to 50 mV and both stages empty.
module adc_scan_stability_qualifier #(
  parameter int SAMPLES_PER_CHANNEL = asq_pkg::DefSamplesPerChannel,
  parameter int CHANNELS            = asq_pkg::DefChannels
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  asq_in_if.sink                        in_if,
  asq_out_if.source                     out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [asq_pkg::ApbAddrW-1:0]  paddr,
  input  logic [asq_pkg::ApbDataW-1:0]  pwdata,
  output logic [asq_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import asq_pkg::*;

  logic [MvW-1:0]     thr_q;
  logic [RegIdxW-1:0] reg_idx;
  logic               mv_valid, mv_ready;
  logic [MvW-1:0]     mv;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ApbAddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrResetMv;
    end else if (psel && penable && pwrite && pready && (reg_idx == RegNoiseThr)) begin
      thr_q <= pwdata[MvW-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegNoiseThr: prdata = ApbDataW'(thr_q);
      default:     prdata = '0;
    endcase
  end

  asq_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .adc_code_i (in_if.adc_code),
    .mv_valid_o (mv_valid),
    .mv_ready_i (mv_ready),
    .mv_o       (mv)
  );

  asq_qualify #(
    .SAMPLES_PER_CHANNEL (SAMPLES_PER_CHANNEL),
    .CHANNELS            (CHANNELS)
  ) u_qualify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thr_i       (thr_q),
    .mv_valid_i  (mv_valid),
    .mv_ready_o  (mv_ready),
    .mv_i        (mv),
    .res_valid_o (out_if.valid),
    .res_ready_i (out_if.ready),
    .res_o       (out_if.data)
  );

endmodule

@@ rtl/asq_in_stage.sv @@
// ----------------------------------------------------------------------------
// Input stage
// Scales each converter code to millivolts and holds it in the input register.
// ----------------------------------------------------------------------------
module asq_in_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [asq_pkg::AdcW-1:0]    adc_code_i,
  output logic                        mv_valid_o,
  input  logic                        mv_ready_i,
  output logic [asq_pkg::MvW-1:0]     mv_o
);
  import asq_pkg::*;

  localparam int ProdW = AdcW + MvW;

  logic [ProdW-1:0] prod;
  logic [MvW-1:0]   q0;
  logic [13:0]      r1;
  logic [2:0]       q1;
  logic [10:0]      r2;
  logic [MvW-1:0]   mv_d, mv_q;
  logic             valid_q;
  logic             load;

  // floor(code * 5000 / 1023): since 1024 = 1023 + 1, each quotient by 1024
  // folds back into the remainder; two folds leave it below twice 1023.
  always_comb begin
    prod = ProdW'(adc_code_i) * ProdW'(5000);
    q0   = prod[ProdW-1:10];
    r1   = 14'(prod[9:0]) + 14'(q0);
    q1   = r1[12:10];
    r2   = 11'(r1[9:0]) + 11'(q1);
    mv_d = q0 + MvW'(q1) + MvW'(r2 >= 11'd1023);
  end

  assign in_ready_o = !valid_q || mv_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mv_q <= mv_d;
    end
  end

  assign mv_valid_o = valid_q;
  assign mv_o       = mv_q;

endmodule

@@ rtl/asq_qualify.sv @@
// ----------------------------------------------------------------------------
// Stability qualifier
// Run and channel counters, step check against the threshold and the result
// register.
// ----------------------------------------------------------------------------
module asq_qualify #(
  parameter int SAMPLES_PER_CHANNEL = asq_pkg::DefSamplesPerChannel,
  parameter int CHANNELS            = asq_pkg::DefChannels
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [asq_pkg::MvW-1:0]  thr_i,
  input  logic                     mv_valid_i,
  output logic                     mv_ready_o,
  input  logic [asq_pkg::MvW-1:0]  mv_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output asq_pkg::asq_result_t     res_o
);
  import asq_pkg::*;

  localparam int SampW = $clog2(SAMPLES_PER_CHANNEL);
  localparam int ChW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [SampW-1:0] LastSample  = SampW'(SAMPLES_PER_CHANNEL - 1);
  localparam logic [ChW-1:0]   LastChannel = ChW'(CHANNELS - 1);

  logic [SampW-1:0] cnt_d, cnt_q;
  logic [ChW-1:0]   ch_d, ch_q;
  logic [MvW-1:0]   prev_q;
  logic             rdy_d, rdy_q;
  logic             res_valid_q;
  asq_result_t      res_d, res_q;
  logic [MvW-1:0]   diff;
  logic             reject, run_done, scan_done, step;

  assign mv_ready_o = !res_valid_q || res_ready_i;
  assign step       = mv_valid_i && mv_ready_o;

  always_comb begin
    diff      = (mv_i >= prev_q) ? (mv_i - prev_q) : (prev_q - mv_i);
    // The first sample of a run has nothing to be compared with.
    reject    = (cnt_q != '0) && (diff > thr_i);
    run_done  = !reject && (cnt_q == LastSample);
    scan_done = run_done && (ch_q == LastChannel);

    cnt_d = cnt_q + SampW'(1);
    ch_d  = ch_q;
    rdy_d = rdy_q;
    if (reject) begin
      cnt_d = '0;
      ch_d  = '0;
      rdy_d = 1'b0;
    end else if (run_done) begin
      cnt_d = '0;
      ch_d  = scan_done ? '0 : ch_q + ChW'(1);
      if (scan_done) begin
        rdy_d = 1'b1;
      end
    end

    res_d.store_valid   = run_done;
    res_d.store_channel = run_done ? ChOutW'(ch_q) : '0;
    res_d.settled_mv    = mv_i;
    res_d.rejected      = reject;
    res_d.scan_complete = scan_done;
    res_d.data_ready    = rdy_d;
    res_d.next_channel  = ChOutW'(ch_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ch_q        <= '0;
      prev_q      <= '0;
      rdy_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (mv_ready_o) begin
        res_valid_q <= mv_valid_i;
      end
      if (step) begin
        cnt_q  <= cnt_d;
        ch_q   <= ch_d;
        prev_q <= mv_i;
        rdy_q  <= rdy_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/asq_checker.sv @@
// ----------------------------------------------------------------------------
// Result checker
// Watches the result channel of the top level for consistent result words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module asq_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input asq_pkg::asq_result_t out_data_i
);
  import asq_pkg::*;

  logic              vld;
  logic              rdy;
  asq_result_t       res;
  logic [ChOutW-1:0] ch_plus1;
  logic              res_cleared;
  logic              res_wrapped;
  logic              mid_scan_store;
  logic              idle_channel;

  assign vld = out_valid_i;
  assign rdy = out_ready_i;
  assign res = out_data_i;

  assign ch_plus1       = res.store_channel + ChOutW'(1);
  // A restart leaves nothing stored, no scan finished, the ready flag clear and the scan back at zero.
  assign res_cleared    = !res.store_valid && !res.scan_complete && !res.data_ready &&
                          (res.next_channel == '0);
  assign res_wrapped    = res.store_valid && res.data_ready && (res.next_channel == '0);
  assign mid_scan_store = vld && res.store_valid && !res.scan_complete;
  assign idle_channel   = !res.store_valid && (res.store_channel != '0);

  `ASQ_ASSERT(a_out_hold, clk_i, rst_ni, vld && !rdy |=> vld && $stable(res))
  `ASQ_ASSERT(a_reject_clears, clk_i, rst_ni, vld && res.rejected |-> res_cleared)
  `ASQ_ASSERT(a_complete_sets, clk_i, rst_ni, vld && res.scan_complete |-> res_wrapped)
  `ASQ_ASSERT(a_channel_steps, clk_i, rst_ni, mid_scan_store |-> res.next_channel == ch_plus1)
  `ASQ_ASSERT_NEVER(a_idle_channel, clk_i, rst_ni, vld && idle_channel)

endmodule

bind adc_scan_stability_qualifier asq_checker u_asq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data)
);

@@ dv/adc_scan_stability_qualifier_tb.sv @@
// ----------------------------------------------------------------------------
// ADC scan stability qualifier testbench
// Sends converter code words through the valid/ready input and checks every
// result word against a cycle-free prediction of the scan. The noise
// threshold is set over the APB port and read back. A directed opening covers
// full-scale steps, the equal-step boundary and a zero threshold. Four random
// phases with different idling mixes follow, and one holds the output off
// for a long stretch.
// ----------------------------------------------------------------------------
module adc_scan_stability_qualifier_tb;
  import asq_pkg::*;

  localparam int SamplesPerChan = DefSamplesPerChannel;
  localparam int ChanCount      = DefChannels;
  localparam int StallLimit     = 2000;
  localparam int HoldCycles     = 200;
  localparam logic [ApbAddrW-1:0] ThrAddr = {RegNoiseThr, 2'b00};

  // Tracks the scan state and queues the result word each code word causes.
  class settle_tracker;
    logic [MvW-1:0] threshold_mv;
    int unsigned    sample_cnt;
    int unsigned    chan_idx;
    int unsigned    prev_mv;
    bit             ready_flag;
    asq_result_t    pending_q[$];
    int unsigned    errors;
    int unsigned    codes_seen;
    int unsigned    words_checked;
    int unsigned    readings;
    int unsigned    scans;
    int unsigned    restarts;

    function new();
      threshold_mv = ThrResetMv;
      sample_cnt   = 0;
      chan_idx     = 0;
      prev_mv      = 0;
      ready_flag   = 0;
      errors       = 0;
    endfunction

    function void set_threshold(logic [ApbDataW-1:0] value);
      threshold_mv = value[MvW-1:0];
    endfunction

    function void take_code(logic [AdcW-1:0] code);
      asq_result_t r;
      int unsigned mv;
      int unsigned step;
      mv   = (32'(code) * 32'd5000) / 32'd1023;
      step = (mv >= prev_mv) ? mv - prev_mv : prev_mv - mv;
      r = '0;
      r.settled_mv = mv[MvW-1:0];
      prev_mv = mv;
      if (sample_cnt > 0 && step > threshold_mv) begin
        r.rejected = 1'b1;
        sample_cnt = 0;
        chan_idx   = 0;
        ready_flag = 0;
        restarts++;
      end else begin
        sample_cnt++;
        if (sample_cnt >= SamplesPerChan) begin
          r.store_valid   = 1'b1;
          r.store_channel = chan_idx[ChOutW-1:0];
          sample_cnt = 0;
          chan_idx++;
          readings++;
        end
        if (chan_idx >= ChanCount) begin
          chan_idx   = 0;
          ready_flag = 1;
          r.scan_complete = 1'b1;
          scans++;
        end
      end
      r.data_ready   = ready_flag;
      r.next_channel = chan_idx[ChOutW-1:0];
      pending_q.push_back(r);
      codes_seen++;
    endfunction

    function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      end
    endfunction

    function void check_word(asq_result_t got);
      asq_result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result word %h arrived with nothing expected", $time, got);
        return;
      end
      want = pending_q.pop_front();
      words_checked++;
      compare_field("store_valid", 32'(want.store_valid), 32'(got.store_valid));
      compare_field("store_channel", 32'(want.store_channel), 32'(got.store_channel));
      compare_field("settled_mv", 32'(want.settled_mv), 32'(got.settled_mv));
      compare_field("rejected", 32'(want.rejected), 32'(got.rejected));
      compare_field("scan_complete", 32'(want.scan_complete), 32'(got.scan_complete));
      compare_field("data_ready", 32'(want.data_ready), 32'(got.data_ready));
      compare_field("next_channel", 32'(want.next_channel), 32'(got.next_channel));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  asq_in_if  in_if();
  asq_out_if out_if();

  settle_tracker tracker = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  adc_scan_stability_qualifier dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) tracker.check_word(out_if.data);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic check_threshold_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ThrAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[MvW-1:0] !== tracker.threshold_mv) begin
      tracker.errors++;
      $display("%0t: threshold readback mismatch, expected %0d, got %0d",
               $time, tracker.threshold_mv, prdata[MvW-1:0]);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_threshold(logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ThrAddr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_threshold(value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    check_threshold_readback();
  endtask

  // Called just after a falling edge; returns just after a falling edge, once the code word has been taken.
  task automatic send_code(logic [AdcW-1:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.adc_code <= code;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.take_code(code);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (tracker.pending_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Mostly clean runs: each run starts at a random code and then moves in
  // steps that usually stay inside the threshold. A few words are pure noise.
  task automatic random_phase(int unsigned count, int unsigned send_pct,
                              int unsigned stall_pct, logic [ApbDataW-1:0] thr,
                              bit squeeze);
    int unsigned      span;
    int               c;
    logic [AdcW-1:0]  code;
    logic [AdcW-1:0]  last_code;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    set_threshold(thr);
    span = thr / 5;
    if (span > 40) span = 40;
    last_code = 10'd512;
    for (int unsigned i = 0; i < count; i++) begin
      if (squeeze && i == 40) hold_req = 1;
      if ($urandom_range(99) < 2 || tracker.sample_cnt == 0) begin
        code = $urandom_range(1023);
      end else begin
        c = int'(last_code) + int'($urandom_range(2 * span)) - int'(span);
        if (c < 0) c = 0;
        if (c > 1023) c = 1023;
        code = c[AdcW-1:0];
      end
      last_code = code;
      send_code(code);
    end
    drain();
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.adc_code  = '0;
    out_if.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    check_threshold_readback();

    // Full-scale jump is rejected, then a steady run settles channel 0.
    send_code(10'd0);
    send_code(10'd1023);
    repeat (SamplesPerChan) send_code(10'd512);
    drain();

    // A step exactly equal to the threshold passes.
    set_threshold(32'd5000);
    repeat (SamplesPerChan / 2) begin
      send_code(10'd0);
      send_code(10'd1023);
    end
    drain();

    // One millivolt tighter and the same step restarts the scan.
    set_threshold(32'd4999);
    send_code(10'd0);
    send_code(10'd1023);
    drain();

    // Zero threshold: any change at all is rejected.
    set_threshold(32'd0);
    send_code(10'd300);
    send_code(10'd300);
    send_code(10'd301);
    drain();

    random_phase(120, 0, 0, 32'd50, 1'b1);
    random_phase(120, 59, 0, 32'd8191, 1'b0);
    random_phase(120, 0, 59, $urandom_range(5000), 1'b0);
    random_phase(120, 26, 26, 32'd0, 1'b0);

    repeat (10) @(posedge clk_i);
    if (tracker.pending_q.size() != 0) begin
      $display("%0t: %0d expected result words never arrived",
               $time, tracker.pending_q.size());
    end
    $display("Checked %0d result words from %0d code words: %0d readings, %0d scans, %0d restarts.",
             tracker.words_checked, tracker.codes_seen, tracker.readings,
             tracker.scans, tracker.restarts);
    $display("Thresholds 0, 50, 4999, 5000, 8191 and random; four idling mixes; a long hold-off.");
    if (tracker.errors == 0 && tracker.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
